// File: hw/rtl/pbdp_pkg.sv
package pbdp_pkg;

  typedef enum logic [3:0] {
    OP_ALLOC   = 4'd0,
    OP_FREE    = 4'd1,
    OP_REF     = 4'd2,
    OP_PUSH    = 4'd3,
    OP_PULL    = 4'd4,
    OP_PUT     = 4'd5,
    OP_RESERVE = 4'd6,
    OP_TRIM    = 4'd7,
    OP_RESET   = 4'd8,
    OP_QUERY   = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOENTRY = 3'd1,
    ST_FREE    = 3'd2,
    ST_BOUNDS  = 3'd3,
    ST_BUSY    = 3'd4
  } status_t;

  // Word index of the headroom register on the register port
  localparam logic REG_HEADROOM = 1'b0;

  localparam logic [11:0] HEADROOM_RESET = 12'd128;
  localparam logic [15:0] REF_MAX        = 16'hFFFF;
  localparam int          ALIGN_MASK     = 7;

  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  handle;
    logic [15:0] size;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  result_handle;
    logic [11:0] position;
    logic [11:0] payload_len;
    logic [11:0] head_room;
    logic [11:0] tail_room;
    logic [15:0] refs;
    logic        released;
  } rsp_t;

  typedef struct packed {
    logic take;
    logic give_back;
  } use_upd_t;

endpackage

// File: hw/rtl/pbdp_entry_ram.sv
module pbdp_entry_ram #(
  parameter int DEPTH = 16,
  parameter int IW    = 4,
  parameter int EW    = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  logic [EW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_idx,
  output logic [EW-1:0] rd_data
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q;
  logic [EW-1:0] byp_data;
  logic          byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Forward a write landing on the same entry in the same cycle as the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q     <= mem[rd_idx];
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_idx == rd_idx);
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

// File: hw/rtl/pbdp_free_find.sv
module pbdp_free_find #(
  parameter int ENTRIES = 16,
  parameter int IW      = 4
) (
  input  logic [ENTRIES-1:0] in_use,
  output logic               found,
  output logic [IW-1:0]      idx
);

  // Lowest free entry wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

endmodule

// File: hw/rtl/pbdp_op_unit.sv
module pbdp_op_unit #(
  parameter int POOL_ENTRIES = 16,
  parameter int BUFFER_BYTES = 2048,
  parameter int IW           = 4,
  parameter int BW           = 12,
  parameter int EW           = 40
) (
  input  pbdp_pkg::cmd_t          cmd,
  input  logic [EW-1:0]           entry,
  input  logic [POOL_ENTRIES-1:0] in_use,
  input  logic                    free_found,
  input  logic [IW-1:0]           free_idx,
  input  logic [11:0]             headroom,
  output pbdp_pkg::rsp_t          rsp,
  output logic                    wr_en,
  output logic [IW-1:0]           wr_idx,
  output logic [EW-1:0]           wr_data,
  output pbdp_pkg::use_upd_t      use_upd
);

  localparam int            CW = ((BW > 16) ? BW : 16) + 2;
  localparam logic [CW-1:0] BB = CW'(BUFFER_BYTES);

  logic [IW-1:0]     idx;
  logic              hit;
  logic              is_alloc;
  logic [CW-1:0]     off;
  logic [CW-1:0]     len;
  logic [CW-1:0]     sz;
  logic [CW-1:0]     tail;
  logic [CW-1:0]     dh;
  logic [CW-1:0]     start_hr;
  logic [CW-1:0]     need;
  logic [CW-1:0]     n_off;
  logic [CW-1:0]     n_len;
  logic [CW-1:0]     n_end;
  logic [CW-1:0]     tr;
  logic [CW-1:0]     pos;
  logic [15:0]       cnt;
  logic [15:0]       n_cnt;
  logic              rel;
  pbdp_pkg::status_t st;

  always_comb begin
    idx      = IW'(cmd.handle);
    hit      = (32'(cmd.handle) < 32'(POOL_ENTRIES)) && in_use[idx];
    is_alloc = (pbdp_pkg::op_t'(cmd.op) == pbdp_pkg::OP_ALLOC);
    off      = CW'(entry[BW-1:0]);
    len      = CW'(entry[2*BW-1:BW]);
    cnt      = entry[EW-1:2*BW];
    sz       = CW'(cmd.size);
    tail     = off + len;
    dh       = CW'(headroom);
    start_hr = (BB >= dh) ? dh : '0;
    need     = (sz + dh + CW'(pbdp_pkg::ALIGN_MASK)) & ~CW'(pbdp_pkg::ALIGN_MASK);

    n_off   = off;
    n_len   = len;
    n_cnt   = cnt;
    pos     = off;
    st      = pbdp_pkg::ST_OK;
    wr_en   = 1'b0;
    rel     = 1'b0;
    use_upd = '0;

    if (is_alloc) begin
      if (need <= BB && free_found) begin
        n_off        = start_hr;
        n_len        = '0;
        n_cnt        = 16'd1;
        pos          = start_hr;
        wr_en        = 1'b1;
        use_upd.take = 1'b1;
      end else begin
        st = pbdp_pkg::ST_NOENTRY;
      end
    end else if (!hit) begin
      st = pbdp_pkg::ST_FREE;
    end else begin
      wr_en = 1'b1;
      unique case (pbdp_pkg::op_t'(cmd.op))
        pbdp_pkg::OP_FREE: begin
          if (cnt > 16'd1) begin
            n_cnt = cnt - 16'd1;
          end else begin
            rel               = 1'b1;
            wr_en             = 1'b0;
            use_upd.give_back = 1'b1;
          end
        end
        pbdp_pkg::OP_REF: begin
          if (cnt == pbdp_pkg::REF_MAX) begin
            st = pbdp_pkg::ST_BUSY;
          end else begin
            n_cnt = cnt + 16'd1;
          end
        end
        pbdp_pkg::OP_PUSH: begin
          if (sz > off) begin
            st = pbdp_pkg::ST_BOUNDS;
          end else begin
            n_off = off - sz;
            n_len = len + sz;
            pos   = off - sz;
          end
        end
        pbdp_pkg::OP_PULL: begin
          if (sz > len) begin
            st = pbdp_pkg::ST_BOUNDS;
          end else begin
            n_off = off + sz;
            n_len = len - sz;
            pos   = off + sz;
          end
        end
        pbdp_pkg::OP_PUT: begin
          if (tail > BB || (BB - tail) < sz) begin
            st = pbdp_pkg::ST_BOUNDS;
          end else begin
            n_len = len + sz;
            pos   = tail;
          end
        end
        pbdp_pkg::OP_RESERVE: begin
          if (len != '0) begin
            st = pbdp_pkg::ST_BUSY;
          end else if (off > BB || (BB - off) < sz) begin
            st = pbdp_pkg::ST_BOUNDS;
          end else begin
            n_off = off + sz;
            pos   = off + sz;
          end
        end
        pbdp_pkg::OP_TRIM: begin
          if (len > sz) begin
            n_len = sz;
          end
        end
        pbdp_pkg::OP_RESET: begin
          n_off = start_hr;
          n_len = '0;
          pos   = start_hr;
        end
        default: begin
        end
      endcase
    end

    n_end = n_off + n_len;
    tr    = (n_end <= BB) ? (BB - n_end) : '0;

    wr_idx  = is_alloc ? free_idx : idx;
    wr_data = {n_cnt, n_len[BW-1:0], n_off[BW-1:0]};

    rsp.status        = st;
    rsp.result_handle = is_alloc ? 4'(free_idx) : cmd.handle;
    rsp.position      = pos[11:0];
    rsp.payload_len   = n_len[11:0];
    rsp.head_room     = n_off[11:0];
    rsp.tail_room     = tr[11:0];
    rsp.refs          = n_cnt;
    rsp.released      = rel;

    // Missing entries and releases report zeros
    if (st == pbdp_pkg::ST_NOENTRY || st == pbdp_pkg::ST_FREE || rel) begin
      rsp.position    = '0;
      rsp.payload_len = '0;
      rsp.head_room   = '0;
      rsp.tail_room   = '0;
      rsp.refs        = '0;
    end
    if (st == pbdp_pkg::ST_NOENTRY) begin
      rsp.result_handle = '0;
    end
  end

endmodule

// File: hw/rtl/packet_buffer_descriptor_pool_unit.sv
// Path: an accepted command and its descriptor read are registered in s1, and its
// result then goes to the response register. Throughput: one item per cycle unless
// a stalled response backs up s1, with a same-entry bypass on the descriptor memory read.
// Reset: in-use flags cleared, default headroom 128, pipeline empty; descriptor
// fields are not cleared and are written on allocate.
module packet_buffer_descriptor_pool_unit #(
  parameter int POOL_ENTRIES = 16,
  parameter int BUFFER_BYTES = 2048
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  pbdp_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pbdp_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int BW = $clog2(BUFFER_BYTES + 1);
  localparam int EW = 2 * BW + 16;

  logic [11:0]             headroom;
  logic [POOL_ENTRIES-1:0] in_use;
  logic                    s1_valid;
  pbdp_pkg::cmd_t          s1_cmd;
  logic                    accept;
  logic                    advance;
  logic [EW-1:0]           entry;
  logic                    free_found;
  logic [IW-1:0]           free_idx;
  pbdp_pkg::rsp_t          result;
  logic                    wr_en;
  logic [IW-1:0]           wr_idx;
  logic [EW-1:0]           wr_data;
  pbdp_pkg::use_upd_t      use_upd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pbdp_pkg::REG_HEADROOM) ? {20'd0, headroom} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      headroom <= pbdp_pkg::HEADROOM_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == pbdp_pkg::REG_HEADROOM) begin
      headroom <= pwdata[11:0];
    end
  end

  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = s1_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= cmd;
    end
  end

  pbdp_entry_ram #(
    .DEPTH (POOL_ENTRIES),
    .IW    (IW),
    .EW    (EW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (advance && wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_idx  (IW'(cmd.handle)),
    .rd_data (entry)
  );

  pbdp_free_find #(
    .ENTRIES (POOL_ENTRIES),
    .IW      (IW)
  ) u_find (
    .in_use (in_use),
    .found  (free_found),
    .idx    (free_idx)
  );

  pbdp_op_unit #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .BUFFER_BYTES (BUFFER_BYTES),
    .IW           (IW),
    .BW           (BW),
    .EW           (EW)
  ) u_op (
    .cmd        (s1_cmd),
    .entry      (entry),
    .in_use     (in_use),
    .free_found (free_found),
    .free_idx   (free_idx),
    .headroom   (headroom),
    .rsp        (result),
    .wr_en      (wr_en),
    .wr_idx     (wr_idx),
    .wr_data    (wr_data),
    .use_upd    (use_upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (advance) begin
      if (use_upd.take) begin
        in_use[wr_idx] <= 1'b1;
      end
      if (use_upd.give_back) begin
        in_use[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule

// File: hw/rtl/pbdp_checker.sv
module pbdp_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input pbdp_pkg::rsp_t rsp
);

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Input only backs up behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> rsp_valid && rsp_stall)
    else $error("command stalled with result side free");

  a_release_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.released |->
      rsp.status == pbdp_pkg::ST_OK && rsp.refs == 16'd0 && rsp.payload_len == 12'd0)
    else $error("released item carries data");

  a_alloc_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == pbdp_pkg::ST_NOENTRY |->
      rsp.result_handle == 4'd0 && rsp.refs == 16'd0 && !rsp.released)
    else $error("failed allocate reports an entry");

endmodule

bind packet_buffer_descriptor_pool_unit pbdp_checker u_pbdp_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// File: tb/tb.sv
module tb;

  localparam int POOL = 16;
  localparam int BUF_BYTES = 2048;
  localparam logic [11:0] HEADROOMS [8] = '{12'd0, 12'd2048, 12'd4095, 12'd7,
                                            12'd2040, 12'd2047, 12'd1, 12'd128};

  class pool_shadow;
    logic [11:0] headroom;
    bit in_use[POOL];
    int offset[POOL];
    int length[POOL];
    int count[POOL];
    pbdp_pkg::rsp_t owed_replies[$];
    int mismatches;
    int checked;
    int releases;

    function new();
      headroom = pbdp_pkg::HEADROOM_RESET;
      for (int i = 0; i < POOL; i++) begin
        in_use[i] = 1'b0;
        offset[i] = 0;
        length[i] = 0;
        count[i] = 0;
      end
    endfunction

    function void set_headroom(logic [11:0] v);
      headroom = v;
    endfunction

    function int start_offset();
      return (BUF_BYTES >= int'(headroom)) ? int'(headroom) : 0;
    endfunction

    function pbdp_pkg::rsp_t entry_reply(pbdp_pkg::status_t st, int h, int pos);
      pbdp_pkg::rsp_t r;
      r.status = st;
      r.result_handle = 4'(h);
      r.position = 12'(pos);
      r.payload_len = 12'(length[h]);
      r.head_room = 12'(offset[h]);
      r.tail_room = (offset[h] + length[h] <= BUF_BYTES) ?
                    12'(BUF_BYTES - offset[h] - length[h]) : 12'd0;
      r.refs = 16'(count[h]);
      r.released = 1'b0;
      return r;
    endfunction

    function pbdp_pkg::rsp_t pool_answer(pbdp_pkg::cmd_t c);
      int h, sz, off, len, tail, need;
      pbdp_pkg::rsp_t r;
      h = int'(c.handle);
      sz = int'(c.size);
      r = '0;
      if (c.op == pbdp_pkg::OP_ALLOC) begin
        need = (sz + int'(headroom) + 7) & ~7;
        if (need <= BUF_BYTES) begin
          for (int i = 0; i < POOL; i++) begin
            if (!in_use[i]) begin
              in_use[i] = 1'b1;
              offset[i] = start_offset();
              length[i] = 0;
              count[i] = 1;
              return entry_reply(pbdp_pkg::ST_OK, i, offset[i]);
            end
          end
        end
        r.status = pbdp_pkg::ST_NOENTRY;
        return r;
      end
      if (!in_use[h]) begin
        r.status = pbdp_pkg::ST_FREE;
        r.result_handle = c.handle;
        return r;
      end
      off = offset[h];
      len = length[h];
      tail = off + len;
      case (c.op)
        pbdp_pkg::OP_FREE: begin
          if (count[h] > 1) begin
            count[h]--;
            return entry_reply(pbdp_pkg::ST_OK, h, off);
          end
          in_use[h] = 1'b0;
          offset[h] = 0;
          length[h] = 0;
          count[h] = 0;
          r.status = pbdp_pkg::ST_OK;
          r.result_handle = c.handle;
          r.released = 1'b1;
          return r;
        end
        pbdp_pkg::OP_REF: begin
          if (count[h] >= int'(pbdp_pkg::REF_MAX))
            return entry_reply(pbdp_pkg::ST_BUSY, h, off);
          count[h]++;
          return entry_reply(pbdp_pkg::ST_OK, h, off);
        end
        pbdp_pkg::OP_PUSH: begin
          if (sz > off) return entry_reply(pbdp_pkg::ST_BOUNDS, h, off);
          offset[h] = off - sz;
          length[h] = len + sz;
          return entry_reply(pbdp_pkg::ST_OK, h, offset[h]);
        end
        pbdp_pkg::OP_PULL: begin
          if (sz > len) return entry_reply(pbdp_pkg::ST_BOUNDS, h, off);
          offset[h] = off + sz;
          length[h] = len - sz;
          return entry_reply(pbdp_pkg::ST_OK, h, offset[h]);
        end
        pbdp_pkg::OP_PUT: begin
          if (tail > BUF_BYTES || BUF_BYTES - tail < sz)
            return entry_reply(pbdp_pkg::ST_BOUNDS, h, off);
          length[h] = len + sz;
          return entry_reply(pbdp_pkg::ST_OK, h, tail);
        end
        pbdp_pkg::OP_RESERVE: begin
          if (len != 0) return entry_reply(pbdp_pkg::ST_BUSY, h, off);
          if (off > BUF_BYTES || BUF_BYTES - off < sz)
            return entry_reply(pbdp_pkg::ST_BOUNDS, h, off);
          offset[h] = off + sz;
          return entry_reply(pbdp_pkg::ST_OK, h, offset[h]);
        end
        pbdp_pkg::OP_TRIM: begin
          if (len > sz) length[h] = sz;
          return entry_reply(pbdp_pkg::ST_OK, h, off);
        end
        pbdp_pkg::OP_RESET: begin
          offset[h] = start_offset();
          length[h] = 0;
          return entry_reply(pbdp_pkg::ST_OK, h, offset[h]);
        end
        // query, and the unused codes that behave like it
        default: return entry_reply(pbdp_pkg::ST_OK, h, off);
      endcase
    endfunction

    function void take_command(pbdp_pkg::cmd_t c);
      owed_replies.push_back(pool_answer(c));
    endfunction

    function string show(pbdp_pkg::rsp_t r);
      return $sformatf("st=%0d h=%0d pos=%0d len=%0d hr=%0d tr=%0d refs=%0d rel=%0d",
                       r.status, r.result_handle, r.position, r.payload_len,
                       r.head_room, r.tail_room, r.refs, r.released);
    endfunction

    function void match_reply(pbdp_pkg::rsp_t got);
      pbdp_pkg::rsp_t want;
      if (owed_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply: %s", show(got));
        return;
      end
      want = owed_replies.pop_front();
      checked++;
      if (got.released === 1'b1) releases++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reply mismatch, expected %s", show(want));
          $display("               actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  pbdp_pkg::cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  pbdp_pkg::rsp_t rsp;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  pool_shadow shadow;
  int cmds_taken = 0;
  int reg_writes = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  packet_buffer_descriptor_pool_unit #(
    .POOL_ENTRIES(POOL),
    .BUFFER_BYTES(BUF_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // Replies go first: a reply never belongs to the item taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) shadow.match_reply(rsp);
      if (cmd_valid && !cmd_stall) begin
        shadow.take_command(cmd);
        cmds_taken++;
      end
      if (psel && penable && pwrite && pready) begin
        shadow.set_headroom(pwdata[11:0]);
        reg_writes++;
      end
    end
  end

  task automatic send_cmd(input logic [3:0] op, input logic [3:0] handle,
                          input logic [15:0] size);
    int taken_so_far;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    taken_so_far = cmds_taken;
    cmd_valid <= 1'b1;
    cmd <= '{op: op, handle: handle, size: size};
    @(negedge clk);
    while (cmds_taken == taken_so_far) @(negedge clk);
  endtask

  // Drop valid, let every owed reply arrive, then give the pipeline a few cycles.
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (shadow.owed_replies.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_headroom(input logic [11:0] v);
    int writes_so_far;
    wait_drained();
    writes_so_far = reg_writes;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {pbdp_pkg::REG_HEADROOM, 2'b00};
    pwdata <= {20'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (reg_writes == writes_so_far) @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] random_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 35) return 16'($urandom_range(0, 24));
    if (p < 65) return 16'($urandom_range(0, 400));
    if (p < 85) return 16'($urandom_range(0, 2100));
    if (p < 95) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd2047;
      2: return 16'd2048;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Mostly address live descriptors so sequences get past the free-entry check.
  function automatic pbdp_pkg::cmd_t random_cmd();
    pbdp_pkg::cmd_t c;
    int pick;
    int live[$];
    pick = $urandom_range(0, 99);
    if (pick < 15) c.op = pbdp_pkg::OP_ALLOC;
    else if (pick < 29) c.op = pbdp_pkg::OP_FREE;
    else if (pick < 37) c.op = pbdp_pkg::OP_REF;
    else if (pick < 47) c.op = pbdp_pkg::OP_PUSH;
    else if (pick < 57) c.op = pbdp_pkg::OP_PULL;
    else if (pick < 69) c.op = pbdp_pkg::OP_PUT;
    else if (pick < 76) c.op = pbdp_pkg::OP_RESERVE;
    else if (pick < 84) c.op = pbdp_pkg::OP_TRIM;
    else if (pick < 89) c.op = pbdp_pkg::OP_RESET;
    else if (pick < 94) c.op = pbdp_pkg::OP_QUERY;
    else c.op = 4'($urandom_range(10, 15));
    for (int i = 0; i < POOL; i++) if (shadow.in_use[i]) live.push_back(i);
    if (live.size() != 0 && $urandom_range(0, 99) < 88)
      c.handle = 4'(live[$urandom_range(0, live.size() - 1)]);
    else
      c.handle = 4'($urandom);
    c.size = random_size();
    return c;
  endfunction

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    pbdp_pkg::cmd_t c;
    shadow = new();
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    rsp_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed walk over one descriptor at the reset headroom of 128.
    sender_idle_pct = 25;
    receiver_stall_pct = 25;
    send_cmd(pbdp_pkg::OP_QUERY, 4'd0, 16'd0);
    send_cmd(pbdp_pkg::OP_ALLOC, 4'd15, 16'hFFFF);
    send_cmd(pbdp_pkg::OP_ALLOC, 4'd0, 16'd1921);
    send_cmd(pbdp_pkg::OP_ALLOC, 4'd0, 16'd1920);
    send_cmd(pbdp_pkg::OP_PUSH, 4'd0, 16'd0);
    send_cmd(pbdp_pkg::OP_PUSH, 4'd0, 16'd129);
    send_cmd(pbdp_pkg::OP_PUSH, 4'd0, 16'd128);
    send_cmd(pbdp_pkg::OP_PULL, 4'd0, 16'd129);
    send_cmd(pbdp_pkg::OP_PULL, 4'd0, 16'd28);
    send_cmd(pbdp_pkg::OP_PUT, 4'd0, 16'd0);
    send_cmd(pbdp_pkg::OP_PUT, 4'd0, 16'd1921);
    send_cmd(pbdp_pkg::OP_PUT, 4'd0, 16'd1920);
    send_cmd(pbdp_pkg::OP_RESERVE, 4'd0, 16'd5);
    send_cmd(pbdp_pkg::OP_TRIM, 4'd0, 16'd3000);
    send_cmd(pbdp_pkg::OP_TRIM, 4'd0, 16'd0);
    send_cmd(pbdp_pkg::OP_RESERVE, 4'd0, 16'd2021);
    send_cmd(pbdp_pkg::OP_RESERVE, 4'd0, 16'd2020);
    send_cmd(pbdp_pkg::OP_RESET, 4'd0, 16'd0);
    send_cmd(4'd15, 4'd0, 16'd0);
    send_cmd(pbdp_pkg::OP_REF, 4'd0, 16'd0);
    send_cmd(pbdp_pkg::OP_FREE, 4'd0, 16'd0);
    send_cmd(pbdp_pkg::OP_FREE, 4'd0, 16'd0);
    send_cmd(pbdp_pkg::OP_FREE, 4'd0, 16'd0);
    // Fill the pool, then ask once more.
    repeat (POOL + 1) send_cmd(pbdp_pkg::OP_ALLOC, 4'($urandom), 16'd0);

    for (int seg = 0; seg < 8; seg++) begin
      write_headroom(HEADROOMS[seg]);
      case (seg % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
        default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
      endcase
      repeat (214) begin
        c = random_cmd();
        send_cmd(c.op, c.handle, c.size);
      end
    end
    wait_drained();

    $display("ran %0d commands over %0d headroom settings, %0d replies checked",
             cmds_taken, reg_writes, shadow.checked);
    $display("%0d descriptors released, %0d mismatches", shadow.releases, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.owed_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/pbdp_pkg.sv
hw/rtl/pbdp_entry_ram.sv
hw/rtl/pbdp_free_find.sv
hw/rtl/pbdp_op_unit.sv
hw/rtl/packet_buffer_descriptor_pool_unit.sv
hw/rtl/pbdp_checker.sv
tb/tb.sv
